// ===== hdl/pbi_pkg.sv =====
`default_nettype none

package pbi_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int FRACTION_BITS = 10;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ST_W   = 22;
    localparam int OFF_W  = 16;
    localparam int HW_W   = 15;
    localparam int DIFF_W = ST_W;
    localparam int DOFF_W = OFF_W + 1;
    localparam int PROD_W = DIFF_W + 1 + DOFF_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int DCNT_W = $clog2(MAG_W + 1);

    localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'((16 << FRACTION_BITS) / 10);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_HALF_WIDTH = '0;

    typedef enum logic [1:0] {
        OPC_INS_LEFT,
        OPC_INS_RIGHT,
        OPC_CLEAR,
        OPC_QUERY
    } opc_t;

    typedef struct packed {
        logic signed [ST_W-1:0]  st;
        logic signed [OFF_W-1:0] off;
    } ent_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_INS_ERR,
        DP_INS_START,
        DP_INS_RD,
        DP_INS_SHIFT,
        DP_INS_PUT,
        DP_Q_DEF,
        DP_Q_RD_FIRST,
        DP_Q_RD_LAST,
        DP_Q_SRCH_INIT,
        DP_Q_RD_MID,
        DP_Q_STEP,
        DP_Q_FIRST_HIT,
        DP_Q_RD_P0,
        DP_Q_RD_P1,
        DP_Q_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_Q_FINISH,
        DP_PUBLISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_INIT,
        S_INS_RD,
        S_INS_CMP,
        S_Q_START,
        S_Q_FIRST,
        S_Q_LAST,
        S_Q_SRD,
        S_Q_SCMP,
        S_Q_P0,
        S_Q_P1,
        S_Q_DINIT,
        S_Q_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   side;
    } cmd_t;

    typedef struct packed {
        opc_t             opcode;
        logic             full_left;
        logic             full_right;
        logic             idx_zero;
        logic             rd_gt;
        logic             short_tab;
        logic             in_span;
        logic             lo_lt_hi;
        logic             lo_zero;
        logic             div_done;
        logic [CNT_W-1:0] left_cnt;
        logic [CNT_W-1:0] right_cnt;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/pbi_ifs.sv =====
`default_nettype none

interface pbi_req_if import pbi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic signed [ST_W-1:0]  point_station;
    logic signed [OFF_W-1:0] point_offset;
    logic signed [ST_W-1:0]  query_station;

    modport source (output valid, opcode, point_station, point_offset, query_station,
                    input ready);
    modport sink (input valid, opcode, point_station, point_offset, query_station,
                  output ready);
endinterface

interface pbi_rsp_if import pbi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OFF_W-1:0] left_offset;
    logic signed [OFF_W-1:0] right_offset;
    logic                    left_found;
    logic                    right_found;
    logic                    table_full_error;

    modport source (output valid, left_offset, right_offset, left_found, right_found,
                    table_full_error, input ready);
    modport sink (input valid, left_offset, right_offset, left_found, right_found,
                  table_full_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/pbi_datapath.sv =====
`default_nettype none

module pbi_datapath import pbi_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output status_t                      status,
    input  wire logic [HW_W-1:0]         half_width,
    input  wire logic [1:0]              opcode,
    input  wire logic signed [ST_W-1:0]  point_station,
    input  wire logic signed [OFF_W-1:0] point_offset,
    input  wire logic signed [ST_W-1:0]  query_station,
    output logic signed [OFF_W-1:0]      left_offset,
    output logic signed [OFF_W-1:0]      right_offset,
    output logic                         left_found,
    output logic                         right_found,
    output logic                         table_full_error
);

    ent_t mem_l [TABLE_DEPTH];
    ent_t mem_r [TABLE_DEPTH];
    ent_t rd_l_reg;
    ent_t rd_r_reg;
    ent_t rd;

    logic [CNT_W-1:0] cnt_reg [2];
    logic [CNT_W-1:0] cnt_cur;

    opc_t                    op_reg;
    logic signed [ST_W-1:0]  ps_reg;
    logic signed [OFF_W-1:0] pl_reg;
    logic signed [ST_W-1:0]  qs_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;

    logic signed [ST_W-1:0]  first_st_reg;
    logic signed [OFF_W-1:0] first_off_reg;
    logic signed [ST_W-1:0]  s0_reg;
    logic signed [OFF_W-1:0] l0_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic [DIFF_W-1:0]        den_reg;
    logic [DIFF_W-1:0]        rem_reg;
    logic [MAG_W-1:0]         quo_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;

    logic signed [OFF_W-1:0] res_off_reg [2];
    logic                    res_found_reg [2];
    logic                    err_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    ent_t                    wr_data;

    logic signed [ST_W:0]    ds_wide;
    logic signed [ST_W:0]    dd_wide;
    logic signed [DOFF_W-1:0] dl;
    logic [PROD_W-1:0]       prod_neg;
    logic [DIFF_W:0]         rem_sh;
    logic                    q_bit;
    logic signed [DOFF_W-1:0] q_signed;
    logic signed [DOFF_W-1:0] res_wide;

    assign rd      = cmd.side ? rd_r_reg : rd_l_reg;
    assign cnt_cur = cnt_reg[cmd.side];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    always_comb
    begin
        unique case (cmd.op)
            DP_INS_RD:     rd_addr = IDX_W'(idx_reg - CNT_W'(1));
            DP_Q_RD_LAST:  rd_addr = IDX_W'(cnt_cur - CNT_W'(1));
            DP_Q_RD_MID:   rd_addr = IDX_W'(mid);
            DP_Q_RD_P0:    rd_addr = IDX_W'(lo_reg - CNT_W'(1));
            DP_Q_RD_P1:    rd_addr = IDX_W'(lo_reg);
            default:       rd_addr = '0;
        endcase
    end

    assign wr_en   = (cmd.op == DP_INS_SHIFT) || (cmd.op == DP_INS_PUT);
    assign wr_addr = IDX_W'(idx_reg);
    assign wr_data = (cmd.op == DP_INS_PUT) ? ent_t'{st: ps_reg, off: pl_reg} : rd;

    always_ff @(posedge clk)
    begin
        if (wr_en && !cmd.side)
            mem_l[wr_addr] <= wr_data;
        if (wr_en && cmd.side)
            mem_r[wr_addr] <= wr_data;
        rd_l_reg <= mem_l[rd_addr];
        rd_r_reg <= mem_r[rd_addr];
    end

    // interpolation arithmetic
    assign ds_wide  = {qs_reg[ST_W-1], qs_reg} - {s0_reg[ST_W-1], s0_reg};
    assign dd_wide  = {rd.st[ST_W-1], rd.st} - {s0_reg[ST_W-1], s0_reg};
    assign dl       = {rd.off[OFF_W-1], rd.off} - {l0_reg[OFF_W-1], l0_reg};
    assign prod_neg = PROD_W'(0) - prod_reg;
    assign rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
    assign q_bit    = rem_sh >= {1'b0, den_reg};
    assign q_signed = neg_reg ? DOFF_W'(0) - $signed(quo_reg[DOFF_W-1:0])
                              : $signed(quo_reg[DOFF_W-1:0]);
    assign res_wide = {l0_reg[OFF_W-1], l0_reg} + q_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end
        else
        begin
            if (cmd.op == DP_CLEAR)
            begin
                cnt_reg[0] <= '0;
                cnt_reg[1] <= '0;
            end
            else if (cmd.op == DP_INS_PUT)
                cnt_reg[cmd.side] <= cnt_cur + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg           <= opc_t'(opcode);
                ps_reg           <= point_station;
                pl_reg           <= point_offset;
                qs_reg           <= query_station;
                res_off_reg[0]   <= '0;
                res_off_reg[1]   <= '0;
                res_found_reg[0] <= 1'b0;
                res_found_reg[1] <= 1'b0;
                err_reg          <= 1'b0;
            end
            DP_INS_ERR:   err_reg <= 1'b1;
            DP_INS_START: idx_reg <= cnt_cur;
            DP_INS_SHIFT: idx_reg <= idx_reg - CNT_W'(1);
            DP_Q_DEF:
            begin
                res_found_reg[cmd.side] <= 1'b0;
                res_off_reg[cmd.side]   <= cmd.side ? OFF_W'(0) - OFF_W'(half_width)
                                                    : OFF_W'(half_width);
            end
            DP_Q_RD_LAST:
            begin
                first_st_reg  <= rd.st;
                first_off_reg <= rd.off;
            end
            DP_Q_SRCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= cnt_cur;
            end
            DP_Q_RD_MID:  mid_reg <= mid;
            DP_Q_STEP:
            begin
                if (rd.st < qs_reg)
                    lo_reg <= mid_reg + CNT_W'(1);
                else
                    hi_reg <= mid_reg;
            end
            DP_Q_FIRST_HIT:
            begin
                res_found_reg[cmd.side] <= 1'b1;
                res_off_reg[cmd.side]   <= first_off_reg;
            end
            DP_Q_RD_P1:
            begin
                s0_reg <= rd.st;
                l0_reg <= rd.off;
            end
            DP_Q_MUL:
            begin
                prod_reg <= $signed({1'b0, ds_wide[DIFF_W-1:0]}) * dl;
                den_reg  <= dd_wide[DIFF_W-1:0];
            end
            DP_DIV_INIT:
            begin
                neg_reg  <= prod_reg[PROD_W-1];
                quo_reg  <= prod_reg[PROD_W-1] ? prod_neg[MAG_W-1:0]
                                               : prod_reg[MAG_W-1:0];
                rem_reg  <= '0;
                dcnt_reg <= DCNT_W'(MAG_W);
            end
            DP_DIV_STEP:
            begin
                rem_reg  <= q_bit ? DIFF_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIFF_W-1:0];
                quo_reg  <= {quo_reg[MAG_W-2:0], q_bit};
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            DP_Q_FINISH:
            begin
                res_found_reg[cmd.side] <= 1'b1;
                res_off_reg[cmd.side]   <= res_wide[OFF_W-1:0];
            end
            DP_PUBLISH:
            begin
                left_offset      <= res_off_reg[0];
                right_offset     <= res_off_reg[1];
                left_found       <= res_found_reg[0];
                right_found      <= res_found_reg[1];
                table_full_error <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.opcode     = op_reg;
        status.full_left  = cnt_reg[0] == CNT_W'(TABLE_DEPTH);
        status.full_right = cnt_reg[1] == CNT_W'(TABLE_DEPTH);
        status.idx_zero   = idx_reg == '0;
        status.rd_gt      = rd.st > ps_reg;
        status.short_tab  = cnt_cur < CNT_W'(2);
        status.in_span    = (first_st_reg <= qs_reg) && (rd.st >= qs_reg);
        status.lo_lt_hi   = lo_reg < hi_reg;
        status.lo_zero    = lo_reg == '0;
        status.div_done   = dcnt_reg == '0;
        status.left_cnt   = cnt_reg[0];
        status.right_cnt  = cnt_reg[1];
    end

endmodule

`default_nettype wire

// ===== hdl/pbi_ctrl.sv =====
`default_nettype none

module pbi_ctrl import pbi_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   side_reg;
    logic   side_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd.op         = DP_NOP;
        cmd.side       = side_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.opcode) inside
                    OPC_INS_LEFT, OPC_INS_RIGHT:
                    begin
                        side_next = status.opcode == OPC_INS_RIGHT;
                        if ((status.opcode == OPC_INS_RIGHT) ? status.full_right
                                                             : status.full_left)
                        begin
                            cmd.op     = DP_INS_ERR;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_INS_INIT;
                    end
                    OPC_CLEAR:
                    begin
                        cmd.op     = DP_CLEAR;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        side_next  = 1'b0;
                        state_next = S_Q_START;
                    end
                endcase
            end
            S_INS_INIT:
            begin
                cmd.op     = DP_INS_START;
                state_next = S_INS_RD;
            end
            S_INS_RD:
            begin
                if (status.idx_zero)
                begin
                    cmd.op     = DP_INS_PUT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_INS_RD;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.rd_gt)
                begin
                    cmd.op     = DP_INS_SHIFT;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.op     = DP_INS_PUT;
                    state_next = S_DONE;
                end
            end
            S_Q_START:
            begin
                if (status.short_tab)
                begin
                    cmd.op = DP_Q_DEF;
                    if (side_reg)
                        state_next = S_DONE;
                    else
                        side_next = 1'b1;
                end
                else
                begin
                    cmd.op     = DP_Q_RD_FIRST;
                    state_next = S_Q_FIRST;
                end
            end
            S_Q_FIRST:
            begin
                cmd.op     = DP_Q_RD_LAST;
                state_next = S_Q_LAST;
            end
            S_Q_LAST:
            begin
                if (status.in_span)
                begin
                    cmd.op     = DP_Q_SRCH_INIT;
                    state_next = S_Q_SRD;
                end
                else
                begin
                    cmd.op = DP_Q_DEF;
                    if (side_reg)
                        state_next = S_DONE;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_Q_START;
                    end
                end
            end
            S_Q_SRD:
            begin
                if (status.lo_lt_hi)
                begin
                    cmd.op     = DP_Q_RD_MID;
                    state_next = S_Q_SCMP;
                end
                else if (status.lo_zero)
                begin
                    cmd.op = DP_Q_FIRST_HIT;
                    if (side_reg)
                        state_next = S_DONE;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_Q_START;
                    end
                end
                else
                begin
                    cmd.op     = DP_Q_RD_P0;
                    state_next = S_Q_P0;
                end
            end
            S_Q_SCMP:
            begin
                cmd.op     = DP_Q_STEP;
                state_next = S_Q_SRD;
            end
            S_Q_P0:
            begin
                cmd.op     = DP_Q_RD_P1;
                state_next = S_Q_P1;
            end
            S_Q_P1:
            begin
                cmd.op     = DP_Q_MUL;
                state_next = S_Q_DINIT;
            end
            S_Q_DINIT:
            begin
                cmd.op     = DP_DIV_INIT;
                state_next = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.op = DP_Q_FINISH;
                    if (side_reg)
                        state_next = S_DONE;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_Q_START;
                    end
                end
                else
                    cmd.op = DP_DIV_STEP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op         = DP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/path_border_interpolator.sv =====
// path border interpolator
// req channel: one word per operation (insert left point, insert right point,
// clear both tables, query both borders at a station)
// rsp channel: exactly one word per request word, in request order
// config: apb register 0 holds the default half width (reset 1638, 1.6 m)
// one request is processed at a time; req.ready is high only when idle
// how each operation runs before rsp.valid rises:
//   clear or dropped insert: acted on at dispatch, then published
//   insert: each entry with a larger station is read and shifted up, then the
//     new point is written into the freed slot
//   query per border: a short table or a station outside the span gives the
//     default, the first station gives the first offset, else a binary search
//     and a multiply feed the 39-step serial divider
//   a query runs both borders in series, left then right
// results sit in an output register; a new request is accepted while an
// earlier result still waits for rsp.ready; a stalled receiver holds the
// next result in the block until the output register frees up
// reset empties both tables and restores the default half width
`default_nettype none

module path_border_interpolator import pbi_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    pbi_req_if.sink                     req,
    pbi_rsp_if.source                   rsp,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [HW_W-1:0] half_width_reg;
    logic            reg_hit;
    cmd_t            cmd;
    status_t         status;
    logic            req_ready;
    logic            rsp_valid;

    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_HALF_WIDTH;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(half_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_width_reg <= HALF_WIDTH_RESET;
        else if (psel && penable && pwrite && reg_hit)
            half_width_reg <= pwdata[HW_W-1:0];
    end

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

    pbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pbi_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .half_width       (half_width_reg),
        .opcode           (req.opcode),
        .point_station    (req.point_station),
        .point_offset     (req.point_offset),
        .query_station    (req.query_station),
        .left_offset      (rsp.left_offset),
        .right_offset     (rsp.right_offset),
        .left_found       (rsp.left_found),
        .right_found      (rsp.right_found),
        .table_full_error (rsp.table_full_error)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.left_cnt <= CNT_W'(TABLE_DEPTH) && status.right_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.table_full_error && (rsp.left_found || rsp.right_found)))
        else $error("error word carries found flags");

endmodule

`default_nettype wire

// ===== tb/tb_path_border_interpolator.sv =====
`default_nettype none

module tb_path_border_interpolator;
    import pbi_pkg::*;

    typedef struct {
        opc_t                    op;
        logic signed [ST_W-1:0]  pst;
        logic signed [OFF_W-1:0] poff;
        logic signed [ST_W-1:0]  qst;
        bit                      typed;
        logic signed [OFF_W-1:0] l_off;
        logic signed [OFF_W-1:0] r_off;
        bit                      l_fnd;
        bit                      r_fnd;
        bit                      err;
    } row_t;

    typedef struct {
        logic signed [OFF_W-1:0] l_off;
        logic signed [OFF_W-1:0] r_off;
        bit                      l_fnd;
        bit                      r_fnd;
        bit                      err;
    } border_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pbi_req_if req_if ();
    pbi_rsp_if rsp_if ();

    path_border_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    logic signed [ST_W-1:0]  stations [2][TABLE_DEPTH];
    logic signed [OFF_W-1:0] offsets [2][TABLE_DEPTH];
    int                      fill [2];
    logic [HW_W-1:0]         half_width;

    border_word_t pending_words [$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    int           sent = 0;
    int           stall_left = 0;

    function automatic bit border_lookup(input int side, input logic signed [ST_W-1:0] s,
                                         output logic signed [OFF_W-1:0] v);
        int    n;
        int    lo;
        longint s0;
        longint s1;
        longint l0;
        longint l1;
        n = fill[side];
        v = '0;
        if (n < 2)
            return 1'b0;
        if (!(stations[side][0] <= s && s <= stations[side][n-1]))
            return 1'b0;
        lo = 0;
        while (lo < n && stations[side][lo] < s)
            lo++;
        if (lo == 0)
        begin
            v = offsets[side][0];
            return 1'b1;
        end
        s0 = stations[side][lo-1];
        s1 = stations[side][lo];
        l0 = offsets[side][lo-1];
        l1 = offsets[side][lo];
        if (s1 <= s0)
        begin
            v = offsets[side][lo];
            return 1'b1;
        end
        v = OFF_W'(l0 + ((longint'(s) - s0) * (l1 - l0)) / (s1 - s0));
        return 1'b1;
    endfunction

    function automatic border_word_t apply_word(input opc_t op, input logic signed [ST_W-1:0] pst,
                                                input logic signed [OFF_W-1:0] poff,
                                                input logic signed [ST_W-1:0] qst);
        border_word_t w;
        int           side;
        int           pos;
        w = '{default: 0};
        case (op)
            OPC_INS_LEFT, OPC_INS_RIGHT:
            begin
                side = (op == OPC_INS_RIGHT) ? 1 : 0;
                if (fill[side] >= TABLE_DEPTH)
                    w.err = 1'b1;
                else
                begin
                    pos = fill[side];
                    while (pos > 0 && stations[side][pos-1] > pst)
                    begin
                        stations[side][pos] = stations[side][pos-1];
                        offsets[side][pos] = offsets[side][pos-1];
                        pos--;
                    end
                    stations[side][pos] = pst;
                    offsets[side][pos] = poff;
                    fill[side]++;
                end
            end
            OPC_CLEAR:
            begin
                fill[0] = 0;
                fill[1] = 0;
            end
            default:
            begin
                w.l_fnd = border_lookup(0, qst, w.l_off);
                if (!w.l_fnd)
                    w.l_off = OFF_W'(half_width);
                w.r_fnd = border_lookup(1, qst, w.r_off);
                if (!w.r_fnd)
                    w.r_off = -OFF_W'(half_width);
            end
        endcase
        return w;
    endfunction

    task automatic send_word(input opc_t op, input logic signed [ST_W-1:0] pst,
                             input logic signed [OFF_W-1:0] poff,
                             input logic signed [ST_W-1:0] qst,
                             input bit typed, input border_word_t typed_word);
        border_word_t w;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.opcode <= op;
        req_if.point_station <= pst;
        req_if.point_offset <= poff;
        req_if.query_station <= qst;
        do
            @(posedge clk);
        while (!req_if.ready);
        w = apply_word(op, pst, poff, qst);
        pending_words.push_back(typed ? typed_word : w);
        sent++;
    endtask

    task automatic send_plain(input opc_t op, input logic signed [ST_W-1:0] pst,
                              input logic signed [OFF_W-1:0] poff,
                              input logic signed [ST_W-1:0] qst);
        send_word(op, pst, poff, qst, 1'b0, '{default: 0});
    endtask

    task automatic drain_and_write(input logic [HW_W-1:0] value);
        req_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_HALF_WIDTH, 2'b00};
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        half_width = value;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %0d %0d %0b %0b %0b", rsp_if.left_offset,
                             rsp_if.right_offset, rsp_if.left_found, rsp_if.right_found,
                             rsp_if.table_full_error);
            end
            else
            begin
                border_word_t e;
                e = pending_words.pop_front();
                if (rsp_if.left_offset !== e.l_off || rsp_if.right_offset !== e.r_off
                    || rsp_if.left_found !== e.l_fnd || rsp_if.right_found !== e.r_fnd
                    || rsp_if.table_full_error !== e.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0b %0b %0b got %0d %0d %0b %0b %0b",
                                 e.l_off, e.r_off, e.l_fnd, e.r_fnd, e.err,
                                 rsp_if.left_offset, rsp_if.right_offset, rsp_if.left_found,
                                 rsp_if.right_found, rsp_if.table_full_error);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    initial
    begin
        #(30_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        row_t                   rows [$];
        border_word_t           tw;
        logic signed [ST_W-1:0] base;
        logic [HW_W-1:0]        widths [5];
        int                     span;
        int                     n;
        int                     sel;
        int                     phase;
        opc_t                   op;

        req_if.valid = 1'b0;
        req_if.opcode = '0;
        req_if.point_station = '0;
        req_if.point_offset = '0;
        req_if.query_station = '0;
        rsp_if.ready = 1'b0;
        fill[0] = 0;
        fill[1] = 0;
        half_width = HALF_WIDTH_RESET;

        // op, point station, point offset, query station, typed, l, r, lf, rf, err
        rows = '{
            '{OPC_QUERY, 0, 0, 0, 1, 1638, -1638, 0, 0, 0},
            '{OPC_INS_LEFT, -2097152, -32768, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, -2097152, 1, 1638, -1638, 0, 0, 0},
            '{OPC_INS_LEFT, 2097151, 32767, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, -2097152, 1, -32768, -1638, 1, 0, 0},
            '{OPC_QUERY, 0, 0, 2097151, 1, 32767, -1638, 1, 0, 0},
            '{OPC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0},
            '{OPC_INS_RIGHT, 100, 500, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_INS_RIGHT, 100, -500, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_INS_RIGHT, 50, 0, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 100, 0, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 50, 0, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 75, 0, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 101, 0, 0, 0, 0, 0, 0},
            '{OPC_CLEAR, -1, -1, -1, 1, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 75, 1, 1638, -1638, 0, 0, 0},
            '{OPC_INS_RIGHT, -1, 7, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_INS_RIGHT, -3, -9, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_INS_LEFT, -3, 1, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_INS_LEFT, 5, -7, 0, 1, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, -2, 0, 0, 0, 0, 0, 0},
            '{OPC_QUERY, 0, 0, 2, 0, 0, 0, 0, 0, 0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            tw = '{rows[i].l_off, rows[i].r_off, rows[i].l_fnd, rows[i].r_fnd, rows[i].err};
            send_word(rows[i].op, rows[i].pst, rows[i].poff, rows[i].qst, rows[i].typed, tw);
        end

        widths[0] = '0;
        widths[1] = '1;
        widths[2] = HW_W'($urandom);
        widths[3] = 1;
        widths[4] = HW_W'($urandom);

        for (phase = 0; phase < 5; phase++)
        begin
            drain_and_write(widths[phase]);
            idle_on = (phase != 4);
            while (sent < rows.size() + 160 * (phase + 1))
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    send_plain(OPC_CLEAR, ST_W'($urandom), OFF_W'($urandom), ST_W'($urandom));
                else if (sel < 3)
                begin
                    op = opc_t'($urandom_range(0, 3));
                    send_plain(op, ST_W'($urandom), OFF_W'($urandom), ST_W'($urandom));
                end
                else if (sel == 3)
                begin
                    // fill one table past its depth
                    op = $urandom_range(0, 1) ? OPC_INS_RIGHT : OPC_INS_LEFT;
                    repeat (TABLE_DEPTH + 2)
                        send_plain(op, ST_W'($urandom_range(0, 5000)), OFF_W'($urandom),
                                   ST_W'($urandom));
                    repeat (4)
                        send_plain(OPC_QUERY, 0, 0, ST_W'($urandom_range(0, 5000)));
                end
                else
                begin
                    base = ST_W'($urandom);
                    case ($urandom_range(0, 2))
                        0: span = 16;
                        1: span = 4096;
                        default: span = 1 << 20;
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        send_plain(OPC_CLEAR, 0, 0, 0);
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        op = $urandom_range(0, 1) ? OPC_INS_RIGHT : OPC_INS_LEFT;
                        send_plain(op, ST_W'(base + $urandom_range(0, span)), OFF_W'($urandom),
                                   ST_W'($urandom));
                    end
                    repeat ($urandom_range(1, 4))
                        send_plain(OPC_QUERY, ST_W'($urandom), OFF_W'($urandom),
                                   ST_W'(base + $urandom_range(0, span + span / 8) - span / 16));
                end
            end
        end

        req_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/pbi_pkg.sv
hdl/pbi_ifs.sv
hdl/pbi_datapath.sv
hdl/pbi_ctrl.sv
hdl/path_border_interpolator.sv
tb/tb_path_border_interpolator.sv
